// ===== hdl/emstd_pkg.sv =====
package emstd_pkg;

    // Number of telegram bytes the deframer holds before it flags overflow.
    localparam int BUFFER_BYTES = 128;

    // Width of the per-frame byte counter, able to hold BUFFER_BYTES itself.
    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int LEN_MAX = (1 << LEN_W) - 1;

    // CRC feedback taps applied when the top bit shifts out.
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h19;

    typedef enum logic [1:0] {
        KIND_POLL     = 2'd0,
        KIND_OK       = 2'd1,
        KIND_BAD      = 2'd2,
        KIND_OVERFLOW = 2'd3
    } frame_kind_t;

    // Action codes of the receive channel.
    localparam logic ACT_DATA  = 1'b0;
    localparam logic ACT_BREAK = 1'b1;

    typedef struct packed {
        logic              action;
        logic [BYTE_W-1:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        frame_kind_t       frame_kind;
        logic [BYTE_W-1:0] first_byte;
        logic [LEN_W-1:0]  frame_length;
        logic [BYTE_W-1:0] computed_crc;
        logic [BYTE_W-1:0] received_crc;
    } frame_result_t;

    // One CRC step: shift left, fold in the polynomial on carry, add the byte.
    function automatic logic [BYTE_W-1:0] crc_fold(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] shifted;
        begin
            shifted = {crc[BYTE_W-2:0], 1'b0};
            if (crc[BYTE_W-1]) begin
                shifted = shifted ^ CRC_POLY;
            end
            return shifted ^ data;
        end
    endfunction

endpackage

// ===== hdl/emstd_frame_track.sv =====
module emstd_frame_track
    import emstd_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          item_fire,
    input  rx_item_t      item,
    output logic          result_valid,
    output frame_result_t result
);

    localparam int MAX_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    logic [CNT_W-1:0]  byte_count_reg,  byte_count_next;
    logic [BYTE_W-1:0] crc_running_reg, crc_running_next;
    logic [BYTE_W-1:0] older_byte_reg,  older_byte_next;
    logic [BYTE_W-1:0] newer_byte_reg,  newer_byte_next;
    logic [BYTE_W-1:0] head_byte_reg,   head_byte_next;
    logic              overflowed_reg,  overflowed_next;

    logic [MAX_W-1:0]  tlen_wide;
    logic [LEN_W-1:0]  tlen;
    logic              is_break;

    assign is_break = (item.action == ACT_BREAK);

    always_comb begin
        tlen_wide = MAX_W'(byte_count_reg) - MAX_W'(1);
        if (tlen_wide > MAX_W'(LEN_MAX)) begin
            tlen = LEN_W'(LEN_MAX);
        end else begin
            tlen = tlen_wide[LEN_W-1:0];
        end
    end

    always_comb begin
        byte_count_next  = byte_count_reg;
        crc_running_next = crc_running_reg;
        older_byte_next  = older_byte_reg;
        newer_byte_next  = newer_byte_reg;
        head_byte_next   = head_byte_reg;
        overflowed_next  = overflowed_reg;

        result_valid        = 1'b0;
        result.frame_kind   = KIND_POLL;
        result.first_byte   = head_byte_reg;
        result.frame_length = '0;
        result.computed_crc = '0;
        result.received_crc = '0;

        if (item_fire) begin
            if (!is_break) begin
                if (byte_count_reg >= CNT_W'(BUFFER_BYTES)) begin
                    overflowed_next = 1'b1;
                end else begin
                    if (byte_count_reg == '0) begin
                        head_byte_next = item.rx_byte;
                    end
                    if (byte_count_reg >= CNT_W'(2)) begin
                        crc_running_next = crc_fold(crc_running_reg, older_byte_reg);
                    end
                    older_byte_next = newer_byte_reg;
                    newer_byte_next = item.rx_byte;
                    byte_count_next = byte_count_reg + CNT_W'(1);
                end
            end else begin
                if (overflowed_reg) begin
                    result_valid      = 1'b1;
                    result.frame_kind = KIND_OVERFLOW;
                end else if (byte_count_reg == CNT_W'(2)) begin
                    result_valid        = 1'b1;
                    result.frame_kind   = KIND_POLL;
                    result.frame_length = LEN_W'(1);
                end else if (byte_count_reg > CNT_W'(2)) begin
                    result_valid        = 1'b1;
                    result.frame_kind   = (crc_running_reg == older_byte_reg) ?
                                          KIND_OK : KIND_BAD;
                    result.frame_length = tlen;
                    result.computed_crc = crc_running_reg;
                    result.received_crc = older_byte_reg;
                end
                // Every break starts a fresh frame.
                byte_count_next  = '0;
                crc_running_next = '0;
                older_byte_next  = '0;
                newer_byte_next  = '0;
                head_byte_next   = '0;
                overflowed_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg  <= '0;
            crc_running_reg <= '0;
            older_byte_reg  <= '0;
            newer_byte_reg  <= '0;
            head_byte_reg   <= '0;
            overflowed_reg  <= 1'b0;
        end else begin
            byte_count_reg  <= byte_count_next;
            crc_running_reg <= crc_running_next;
            older_byte_reg  <= older_byte_next;
            newer_byte_reg  <= newer_byte_next;
            head_byte_reg   <= head_byte_next;
            overflowed_reg  <= overflowed_next;
        end
    end

    // The counter never runs past the buffer size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= CNT_W'(BUFFER_BYTES))
        else $error("byte counter exceeded buffer size");

    // Overflow can only be flagged once the buffer is full.
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        overflowed_reg |-> (byte_count_reg == CNT_W'(BUFFER_BYTES)))
        else $error("overflow flagged with buffer not full");

    // A break always leaves the tracker cleared.
    a_break_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_fire && is_break) |=> (byte_count_reg == '0 && !overflowed_reg))
        else $error("frame state not cleared after break");

endmodule

// ===== hdl/ems_telegram_deframer_crc_check_unit.sv =====
// Bus telegram deframer with CRC check. Each input transaction on s_data is one UART
// receive event: a data byte (action 0) or a break (action 1). A break closes the frame;
// the byte just before it is the break's null character and is dropped, and the bytes
// before that form the telegram. A one-byte telegram is reported as a poll, a longer one
// as CRC ok or bad, with the 8-bit CRC (polynomial 0x19) run over all telegram bytes but
// the last and compared with that last byte. Frames longer than BUFFER_BYTES report an
// overflow; a break after zero or one byte produces nothing. Data bytes never produce a
// result transaction. The CRC is folded in as bytes arrive through a two-byte delay
// line, so no frame buffer is kept. Throughput is one input transaction per clock cycle
// while s_ready is high: each transaction costs a single CRC step between the frame
// state registers and the result register. A result appears on m_data in the cycle
// after the break is accepted and is held in that register until taken; s_ready stays
// high while the result register is empty or is being emptied in the same cycle.
module ems_telegram_deframer_crc_check_unit
    import emstd_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rx_item_t      s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output frame_result_t m_data
);

    logic          s_fire;
    logic          res_valid;
    frame_result_t res;

    logic          m_valid_reg, m_valid_next;
    frame_result_t m_data_reg;

    // Accept whenever the result slot is free or drains this cycle.
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    emstd_frame_track u_track (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_fire    (s_fire),
        .item         (s_data),
        .result_valid (res_valid),
        .result       (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (res_valid) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // The payload register needs no reset; it loads only with a new result.
    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A fresh result only follows an accepted break.
    a_res_after_break: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |->
            ($past(s_fire) && $past(s_data.action) == ACT_BREAK))
        else $error("result without a preceding break");

    // A poll carries a length of one and zero CRC fields.
    a_poll_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.frame_kind == KIND_POLL) |->
            (m_data_reg.frame_length == LEN_W'(1) && m_data_reg.computed_crc == '0 &&
             m_data_reg.received_crc == '0))
        else $error("poll result with nonzero fields");

    // An ok verdict means the two CRC fields agree, a bad one that they differ.
    a_crc_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.frame_kind == KIND_OK ||
                         m_data_reg.frame_kind == KIND_BAD)) |->
            ((m_data_reg.computed_crc == m_data_reg.received_crc) ==
             (m_data_reg.frame_kind == KIND_OK)))
        else $error("CRC verdict inconsistent with CRC fields");

    // An overflow report carries zero length.
    a_ovf_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.frame_kind == KIND_OVERFLOW) |->
            (m_data_reg.frame_length == '0))
        else $error("overflow result with nonzero length");

endmodule
